### design/tts_pkg.sv
package tts_pkg;

  localparam int PANEL_WIDTH_DEF  = 480;
  localparam int PANEL_HEIGHT_DEF = 800;
  localparam int FIFO_DEPTH_DEF   = 4;

  localparam logic [7:0] ST_READY = 8'h80;
  localparam logic [7:0] ST_HOME  = 8'h10;
  localparam logic [7:0] ST_COUNT = 8'h0F;

  localparam logic [3:0]  RST_ORIENT    = 4'd0;
  localparam logic [15:0] RST_MAX_X     = 16'd4095;
  localparam logic [15:0] RST_MAX_Y     = 16'd4095;
  localparam logic [15:0] RST_TAP_SLOP  = 16'd10;
  localparam logic [15:0] RST_SWIPE_MIN = 16'd40;
  localparam logic [15:0] RST_SWIPE_MS  = 16'd1000;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIENT    = 3'd0,
    CFG_MAX_X     = 3'd1,
    CFG_MAX_Y     = 3'd2,
    CFG_TAP_SLOP  = 3'd3,
    CFG_SWIPE_MIN = 3'd4,
    CFG_SWIPE_MS  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_TAP   = 2'd1,
    GEST_SWIPE = 2'd2
  } gesture_t;

  typedef struct packed {
    logic        status_ok;
    logic [7:0]  status_byte;
    logic        point_ok;
    logic [63:0] point_record;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        home_pressed;
    logic        home_released;
    gesture_t    gesture;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic [3:0]  contact_count;
  } out_item_t;

  typedef struct packed {
    logic       home_pressed;
    logic       home_released;
    gesture_t   gesture;
    logic [3:0] contact_count;
  } meta_t;

  // raw coordinates waiting for fraction conversion
  typedef struct packed {
    meta_t       meta;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
  } q_item_t;

endpackage

### design/tts_front.sv
module tts_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  tts_pkg::in_item_t                 in_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  output tts_pkg::q_item_t                  push_item
);
  import tts_pkg::*;

  logic [3:0]  orient_r;
  logic [15:0] max_x_r, max_y_r, tap_slop_r, swipe_min_r, swipe_ms_r;

  logic        touch_active_r, touch_active_nxt;
  logic        home_held_r, home_held_nxt;
  logic [15:0] down_x_r, down_x_nxt, down_y_r, down_y_nxt;
  logic [15:0] latest_x_r, latest_x_nxt, latest_y_r, latest_y_nxt;
  logic [31:0] down_time_r, down_time_nxt;

  logic        accept, rdy, home;
  logic [7:0]  cnt8;
  logic [3:0]  count;
  logic [15:0] rx, ry, sw_x, sw_y, cl_x, cl_y, pt_x, pt_y, adx, ady;
  logic [31:0] dur;
  logic        is_tap, is_swipe;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r    <= RST_ORIENT;
      max_x_r     <= RST_MAX_X;
      max_y_r     <= RST_MAX_Y;
      tap_slop_r  <= RST_TAP_SLOP;
      swipe_min_r <= RST_SWIPE_MIN;
      swipe_ms_r  <= RST_SWIPE_MS;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIENT:    orient_r    <= cfg_data[3:0];
        CFG_MAX_X:     max_x_r     <= cfg_data;
        CFG_MAX_Y:     max_y_r     <= cfg_data;
        CFG_TAP_SLOP:  tap_slop_r  <= cfg_data;
        CFG_SWIPE_MIN: swipe_min_r <= cfg_data;
        CFG_SWIPE_MS:  swipe_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy   = in_data.status_ok && ((in_data.status_byte & ST_READY) != 8'd0);
    home  = (in_data.status_byte & ST_HOME) != 8'd0;
    cnt8  = in_data.status_byte & ST_COUNT;
    count = cnt8[3:0];

    // coordinates start at byte zero or byte one
    rx = orient_r[3] ? in_data.point_record[15:0]  : in_data.point_record[23:8];
    ry = orient_r[3] ? in_data.point_record[31:16] : in_data.point_record[39:24];
    sw_x = orient_r[0] ? ry : rx;
    sw_y = orient_r[0] ? rx : ry;
    cl_x = (sw_x > max_x_r) ? max_x_r : sw_x;
    cl_y = (sw_y > max_y_r) ? max_y_r : sw_y;
    pt_x = orient_r[1] ? (max_x_r - cl_x) : cl_x;
    pt_y = orient_r[2] ? (max_y_r - cl_y) : cl_y;

    adx = (latest_x_r >= down_x_r) ? (latest_x_r - down_x_r) : (down_x_r - latest_x_r);
    ady = (latest_y_r >= down_y_r) ? (latest_y_r - down_y_r) : (down_y_r - latest_y_r);
    dur = in_data.now_ms - down_time_r;
    is_tap   = (adx <= tap_slop_r) && (ady <= tap_slop_r);
    is_swipe = (dur <= 32'(swipe_ms_r)) && ((adx >= swipe_min_r) || (ady >= swipe_min_r));

    push_item = '0;
    if (rdy) begin
      push_item.meta.home_pressed  = home && !home_held_r;
      push_item.meta.home_released = !home && home_held_r;
      push_item.meta.contact_count = count;
      if (count == 4'd0 && touch_active_r) begin
        if (is_tap) begin
          push_item.meta.gesture = GEST_TAP;
          push_item.sx = down_x_r;
          push_item.sy = down_y_r;
        end else if (is_swipe) begin
          push_item.meta.gesture = GEST_SWIPE;
          push_item.sx = down_x_r;
          push_item.sy = down_y_r;
          push_item.ex = latest_x_r;
          push_item.ey = latest_y_r;
        end
      end
    end

    touch_active_nxt = touch_active_r;
    home_held_nxt    = home_held_r;
    down_x_nxt       = down_x_r;
    down_y_nxt       = down_y_r;
    latest_x_nxt     = latest_x_r;
    latest_y_nxt     = latest_y_r;
    down_time_nxt    = down_time_r;
    if (rdy) begin
      home_held_nxt = home;
      if (count == 4'd0) begin
        touch_active_nxt = 1'b0;
      end else if (in_data.point_ok) begin
        if (!touch_active_r) begin
          touch_active_nxt = 1'b1;
          down_x_nxt       = pt_x;
          down_y_nxt       = pt_y;
          down_time_nxt    = in_data.now_ms;
        end
        latest_x_nxt = pt_x;
        latest_y_nxt = pt_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_active_r <= 1'b0;
      home_held_r    <= 1'b0;
      down_x_r       <= '0;
      down_y_r       <= '0;
      latest_x_r     <= '0;
      latest_y_r     <= '0;
      down_time_r    <= '0;
    end else if (accept) begin
      touch_active_r <= touch_active_nxt;
      home_held_r    <= home_held_nxt;
      down_x_r       <= down_x_nxt;
      down_y_r       <= down_y_nxt;
      latest_x_r     <= latest_x_nxt;
      latest_y_r     <= latest_y_nxt;
      down_time_r    <= down_time_nxt;
    end
  end

`ifndef SYNTHESIS
  a_gesture_ends_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && push_item.meta.gesture != GEST_NONE) |=> !touch_active_r)
    else $error("touch still active after a gesture");

  a_gesture_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push_item.meta.gesture != GEST_NONE) |-> (push_item.meta.contact_count == 4'd0))
    else $error("gesture reported with contacts present");
`endif

endmodule

### design/tts_fifo.sv
module tts_fifo #(
  parameter int DEPTH = tts_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_stall,
  input  tts_pkg::q_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_stall,
  output tts_pkg::q_item_t pop_item
);
  import tts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 push, pop;

  assign push_stall = (count_r == CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### design/tts_back.sv
module tts_back #(
  parameter int PANEL_WIDTH  = tts_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tts_pkg::PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_stall,
  input  tts_pkg::q_item_t   pop_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_data
);
  import tts_pkg::*;

  localparam logic [15:0] DIV_X   = 16'(PANEL_WIDTH);
  localparam logic [15:0] DIV_Y   = 16'(PANEL_HEIGHT);
  localparam logic [31:0] RECIP_X = 32'(64'hFFFF_FFFF / PANEL_WIDTH);
  localparam logic [31:0] RECIP_Y = 32'(64'hFFFF_FFFF / PANEL_HEIGHT);

  logic        advance;
  logic        v1_r, v2_r, out_valid_r;
  meta_t       meta1_r, meta2_r;
  logic [15:0] raw   [4];
  logic [15:0] res   [4];
  logic [29:0] n1_r  [4];
  logic [29:0] q1_r  [4];
  logic [29:0] n2_r  [4];
  logic [29:0] q2_r  [4];
  logic [29:0] p2_r  [4];
  out_item_t   out_r;

  assign advance   = !(out_valid_r && out_stall);
  assign pop_stall = !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign raw[0] = pop_item.sx;
  assign raw[1] = pop_item.sy;
  assign raw[2] = pop_item.ex;
  assign raw[3] = pop_item.ey;

  // floor(v * 2^14 / size): reciprocal estimate, then one correction step
  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam logic [15:0] DIV   = (i % 2 == 0) ? DIV_X : DIV_Y;
    localparam logic [31:0] RECIP = (i % 2 == 0) ? RECIP_X : RECIP_Y;

    logic [29:0] n_in;
    logic [61:0] p1;
    logic [45:0] p2;
    logic [29:0] rem, q_fix;

    assign n_in  = {raw[i], 14'd0};
    assign p1    = 62'(n_in) * 62'(RECIP);
    assign p2    = 46'(q1_r[i]) * 46'(DIV);
    assign rem   = n2_r[i] - p2_r[i];
    assign q_fix = q2_r[i] + ((rem >= 30'(DIV)) ? 30'd1 : 30'd0);
    assign res[i] = (q_fix > 30'd65535) ? 16'hFFFF : q_fix[15:0];

    always_ff @(posedge clk) begin
      if (advance) begin
        n1_r[i] <= n_in;
        q1_r[i] <= p1[61:32];
        n2_r[i] <= n1_r[i];
        q2_r[i] <= q1_r[i];
        p2_r[i] <= p2[29:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= pop_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      meta1_r               <= pop_item.meta;
      meta2_r               <= meta1_r;
      out_r.home_pressed    <= meta2_r.home_pressed;
      out_r.home_released   <= meta2_r.home_released;
      out_r.gesture         <= meta2_r.gesture;
      out_r.contact_count   <= meta2_r.contact_count;
      out_r.start_x         <= res[0];
      out_r.start_y         <= res[1];
      out_r.end_x           <= res[2];
      out_r.end_y           <= res[3];
    end
  end

`ifndef SYNTHESIS
  a_end_only_swipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.gesture != GEST_SWIPE) |-> (out_r.end_x == 16'd0 && out_r.end_y == 16'd0))
    else $error("end point set without a swipe");

  a_start_only_gesture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.gesture == GEST_NONE) |->
      (out_r.start_x == 16'd0 && out_r.start_y == 16'd0))
    else $error("start point set without a gesture");
`endif

endmodule

### design/touch_tap_swipe_classifier_top.sv
// touch tap and swipe classifier
// one controller report enters per transfer on the in_ channel (in_valid,
// in_stall, in_data); exactly one result leaves per report on the out_ channel
// (out_valid, out_stall, out_data), in order
// configuration registers are written over cfg_valid/cfg_ready with a
// register index and 16-bit data; cfg_ready is always high
// the front stage decodes the report, updates the touch state and classifies
// the gesture in the cycle of the transfer, then queues the raw points
// the back stage converts points to Q2.14 fractions in a three-stage pipeline
// of two multipliers per lane, one report per cycle while out_stall is low;
// while out_stall is high and a result waits, the back pipeline holds and
// the queue fills; in_stall rises once the queue is full and drops as soon
// as an entry frees
// synchronous reset clears touch state, queue and valid flags and loads the
// register defaults
module touch_tap_swipe_classifier_top #(
  parameter int PANEL_WIDTH  = tts_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tts_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tts_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tts_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import tts_pkg::*;

  q_item_t push_item, pop_item;
  logic    pop_valid, pop_stall;

  tts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push_item (push_item)
  );

  tts_fifo #(
    .DEPTH (FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_item   (pop_item)
  );

  tts_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/gesture_checker.sv
module gesture_checker #(
  parameter int PANEL_W = tts_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_H = tts_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  tts_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tts_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  logic [3:0]  orient;
  logic [15:0] lim_x;
  logic [15:0] lim_y;
  logic [15:0] slop;
  logic [15:0] swipe_min;
  logic [15:0] swipe_ms;

  logic        touching;
  logic        key_down;
  logic [15:0] first_x;
  logic [15:0] first_y;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [31:0] first_ms;

  out_item_t   expected_q[$];

  initial begin
    fail_count = 0;
    waiting = 0;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (fail_count < 40) begin
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    end
    fail_count++;
  endtask

  function automatic logic [15:0] to_fraction(logic [15:0] v, int size);
    logic [31:0] num;
    logic [31:0] q;
    num = {2'b00, v, 14'd0};
    q = num / size;
    return (q > 32'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic out_item_t classify_report(in_item_t r);
    out_item_t   res;
    logic        key;
    logic [3:0]  cnt;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [31:0] span;
    int          off;
    res = '0;
    if (r.status_ok && (r.status_byte & ST_READY) != 0) begin
      key = (r.status_byte & ST_HOME) != 0;
      cnt = 4'(r.status_byte & ST_COUNT);
      res.home_pressed = key && !key_down;
      res.home_released = !key && key_down;
      key_down = key;
      res.contact_count = cnt;
      if (cnt == 0) begin
        if (touching) begin
          dx = (last_x >= first_x) ? last_x - first_x : first_x - last_x;
          dy = (last_y >= first_y) ? last_y - first_y : first_y - last_y;
          span = r.now_ms - first_ms;
          if (dx <= slop && dy <= slop) begin
            res.gesture = GEST_TAP;
            res.start_x = to_fraction(first_x, PANEL_W);
            res.start_y = to_fraction(first_y, PANEL_H);
          end else if (span <= {16'd0, swipe_ms} && (dx >= swipe_min || dy >= swipe_min)) begin
            res.gesture = GEST_SWIPE;
            res.start_x = to_fraction(first_x, PANEL_W);
            res.start_y = to_fraction(first_y, PANEL_H);
            res.end_x = to_fraction(last_x, PANEL_W);
            res.end_y = to_fraction(last_y, PANEL_H);
          end
          touching = 1'b0;
        end
      end else if (r.point_ok) begin
        off = orient[3] ? 0 : 8;
        rx = r.point_record[off +: 16];
        ry = r.point_record[off + 16 +: 16];
        px = orient[0] ? ry : rx;
        py = orient[0] ? rx : ry;
        if (px > lim_x) px = lim_x;
        if (py > lim_y) py = lim_y;
        if (orient[1]) px = lim_x - px;
        if (orient[2]) py = lim_y - py;
        if (!touching) begin
          touching = 1'b1;
          first_x = px;
          first_y = py;
          first_ms = r.now_ms;
        end
        last_x = px;
        last_y = py;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      orient = RST_ORIENT;
      lim_x = RST_MAX_X;
      lim_y = RST_MAX_Y;
      slop = RST_TAP_SLOP;
      swipe_min = RST_SWIPE_MIN;
      swipe_ms = RST_SWIPE_MS;
      touching = 1'b0;
      key_down = 1'b0;
      first_x = '0;
      first_y = '0;
      last_x = '0;
      last_y = '0;
      first_ms = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIENT:    orient = cfg_data[3:0];
          CFG_MAX_X:     lim_x = cfg_data;
          CFG_MAX_Y:     lim_y = cfg_data;
          CFG_TAP_SLOP:  slop = cfg_data;
          CFG_SWIPE_MIN: swipe_min = cfg_data;
          CFG_SWIPE_MS:  swipe_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, gesture", out_data.gesture, GEST_NONE);
        end else begin
          want = expected_q.pop_front();
          if (out_data.home_pressed !== want.home_pressed)
            report_mismatch("home_pressed", out_data.home_pressed, want.home_pressed);
          if (out_data.home_released !== want.home_released)
            report_mismatch("home_released", out_data.home_released, want.home_released);
          if (out_data.gesture !== want.gesture)
            report_mismatch("gesture", out_data.gesture, want.gesture);
          if (out_data.start_x !== want.start_x)
            report_mismatch("start_x", out_data.start_x, want.start_x);
          if (out_data.start_y !== want.start_y)
            report_mismatch("start_y", out_data.start_y, want.start_y);
          if (out_data.end_x !== want.end_x)
            report_mismatch("end_x", out_data.end_x, want.end_x);
          if (out_data.end_y !== want.end_y)
            report_mismatch("end_y", out_data.end_y, want.end_y);
          if (out_data.contact_count !== want.contact_count)
            report_mismatch("contact_count", out_data.contact_count, want.contact_count);
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(classify_report(in_data));
      end
    end
    waiting = expected_q.size();
  end

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  localparam int RUN_LIMIT = 300000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int          fail_count;
  int          waiting;
  int          cycles;
  int          sent_items;
  bit          idle_on;
  bit          long_hold_go;
  logic        home_dn;
  logic [31:0] clock_ms;

  logic [3:0]  cur_mode;
  logic [15:0] cur_max_x;
  logic [15:0] cur_max_y;
  logic [15:0] cur_slop;
  logic [15:0] cur_min;
  logic [15:0] cur_ms;

  touch_tap_swipe_classifier_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gesture_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold-off
  initial begin : receiver
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !hold_done) begin
        hold_done = 1;
        stall_left = 80;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_report(logic sok, logic [7:0] st, logic pok,
                                           logic [63:0] rec, logic [31:0] now);
    in_item_t it;
    it.status_ok = sok;
    it.status_byte = st;
    it.point_ok = pok;
    it.point_record = rec;
    it.now_ms = now;
    return it;
  endfunction

  function automatic logic [63:0] place_point(logic [15:0] x, logic [15:0] y);
    logic [63:0] rec;
    int off;
    rec = {$urandom, $urandom};
    off = cur_mode[3] ? 0 : 8;
    rec[off +: 32] = cur_mode[0] ? {x, y} : {y, x};
    return rec;
  endfunction

  function automatic logic [7:0] ready_status(logic [3:0] cnt);
    logic [1:0] spare;
    spare = 2'($urandom_range(0, 3));
    return {1'b1, spare, home_dn, cnt};
  endfunction

  function automatic logic [15:0] pick_coord(logic [15:0] lim);
    logic [15:0] v;
    v = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, lim));
    return v;
  endfunction

  function automatic logic [15:0] clip16(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_report(in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_settings(logic [3:0] mode, logic [15:0] mx, logic [15:0] my,
                                logic [15:0] sl, logic [15:0] smin, logic [15:0] sms);
    write_reg(CFG_ORIENT, {12'd0, mode});
    write_reg(CFG_MAX_X, mx);
    write_reg(CFG_MAX_Y, my);
    write_reg(CFG_TAP_SLOP, sl);
    write_reg(CFG_SWIPE_MIN, smin);
    write_reg(CFG_SWIPE_MS, sms);
    cfg_valid <= 1'b0;
    cur_mode = mode;
    cur_max_x = mx;
    cur_max_y = my;
    cur_slop = sl;
    cur_min = smin;
    cur_ms = sms;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic touch_gesture();
    int kind;
    int n;
    int span;
    int mag;
    int part;
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [15:0] mx;
    logic [15:0] my;
    logic [3:0]  cnt;
    kind = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) home_dn = !home_dn;
    bx = pick_coord(cur_max_x);
    by = pick_coord(cur_max_y);
    case (kind)
      0: mag = $urandom_range(0, cur_slop);
      1: mag = cur_min + $urandom_range(0, 60);
      2: mag = $urandom_range(cur_slop, cur_min);
      default: mag = $urandom_range(0, 4000);
    endcase
    part = $urandom_range(0, mag);
    if ($urandom_range(0, 1) == 0) begin
      ex = clip16($urandom_range(0, 1) ? bx + mag : bx - mag);
      ey = clip16($urandom_range(0, 1) ? by + part : by - part);
    end else begin
      ex = clip16($urandom_range(0, 1) ? bx + part : bx - part);
      ey = clip16($urandom_range(0, 1) ? by + mag : by - mag);
    end
    case (kind)
      1: span = $urandom_range(0, cur_ms);
      2: span = $urandom_range(0, 3000);
      default: span = $urandom_range(0, 1500);
    endcase
    n = $urandom_range(2, 5);
    cnt = 4'($urandom_range(1, 15));
    send_report(make_report(1'b1, ready_status(cnt), 1'b1, place_point(bx, by), clock_ms));
    for (int i = 1; i < n; i++) begin
      clock_ms += span / n;
      mx = (i == n - 1) ? ex : clip16((bx + ex) / 2);
      my = (i == n - 1) ? ey : clip16((by + ey) / 2);
      cnt = 4'($urandom_range(1, 15));
      send_report(make_report(1'b1, ready_status(cnt), $urandom_range(0, 9) != 0,
                              place_point(mx, my), clock_ms));
    end
    clock_ms += span - (n - 1) * (span / n);
    if ($urandom_range(0, 3) == 0) home_dn = !home_dn;
    send_report(make_report(1'b1, ready_status(4'd0), 1'($urandom_range(0, 1)),
                            {$urandom, $urandom}, clock_ms));
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 3)) begin
      send_report(make_report(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom));
    end
  endtask

  initial begin : stimulus
    int first_sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1;
    long_hold_go = 0;
    home_dn = 1'b0;
    sent_items = 0;
    clock_ms = 32'd0;
    cur_mode = RST_ORIENT;
    cur_max_x = RST_MAX_X;
    cur_max_y = RST_MAX_Y;
    cur_slop = RST_TAP_SLOP;
    cur_min = RST_SWIPE_MIN;
    cur_ms = RST_SWIPE_MS;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // status not read, then not ready
    send_report(make_report(1'b0, 8'hFF, 1'b1, '1, '1));
    send_report(make_report(1'b1, 8'h7F, 1'b1, '1, '1));
    // home key press and release with no touch
    send_report(make_report(1'b1, 8'h90, 1'b0, '0, 32'd0));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd0));
    // contacts but point unread
    send_report(make_report(1'b1, 8'h83, 1'b0, '1, 32'd100));
    // tap that lasts long
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd100, 16'd200), 32'd200));
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd105, 16'd195), 32'd250));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd5000));
    // swipe across the timestamp wrap, saturating fractions
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd0, 16'd0), 32'hFFFF_FF00));
    send_report(make_report(1'b1, 8'h82, 1'b1, place_point(16'd4095, 16'd4095),
                            32'hFFFF_FFF0));
    send_report(make_report(1'b1, 8'h80, 1'b1, '0, 32'h0000_0010));
    // clamp of both coordinates
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'hFFFF, 16'hFFFF), 32'd1000));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd1001));
    // moved past slop but short of a swipe
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd1000, 16'd1000), 32'd2000));
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd1020, 16'd1000), 32'd2010));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd2020));
    // long move that takes too long
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd500, 16'd500), 32'd3000));
    send_report(make_report(1'b1, 8'h81, 1'b1, place_point(16'd700, 16'd500), 32'd3100));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd5000));
    // zero contacts with no touch active
    send_report(make_report(1'b1, 8'hE0, 1'b1, '1, 32'd6000));
    // full contact count with home key down, released on touch end
    send_report(make_report(1'b1, 8'h9F, 1'b1, place_point(16'd4095, 16'd0), 32'd7000));
    send_report(make_report(1'b1, 8'h80, 1'b0, '0, 32'd7005));
    clock_ms = 32'd8000;

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: write_settings(4'hF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        1: write_settings(4'h0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: write_settings(4'($urandom_range(0, 15)), 16'($urandom_range(100, 4095)),
                                16'($urandom_range(100, 4095)), 16'($urandom_range(0, 30)),
                                16'($urandom_range(10, 200)), 16'($urandom_range(50, 2000)));
      endcase
      if (p == 2) long_hold_go = 1;
      first_sent = sent_items;
      while (sent_items - first_sent < 80) begin
        idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) == 0) begin
          clock_ms = $urandom_range(0, 1) ? $urandom
                                          : $urandom_range(32'hFFFF_F000, 32'hFFFF_FFFF);
        end else begin
          clock_ms += $urandom_range(0, 3000);
        end
        if ($urandom_range(0, 9) < 7) begin
          touch_gesture();
        end else begin
          line_noise();
        end
      end
    end

    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### files.f
design/tts_pkg.sv
design/tts_front.sv
design/tts_fifo.sv
design/tts_back.sv
design/touch_tap_swipe_classifier_top.sv
test/gesture_checker.sv
test/testbench.sv
